@@ rtl/activity_window_classifier_assert.svh @@
// Assertion macros shared by the activity window classifier RTL
`ifndef ACTIVITY_WINDOW_CLASSIFIER_ASSERT_SVH
`define ACTIVITY_WINDOW_CLASSIFIER_ASSERT_SVH

// property that must hold every clock outside reset
`define AWC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("%m failed");

`endif

@@ rtl/awc_pkg.sv @@
// Package: default sizes, mode and register codes, reset values and state type for the classifier
package awc_pkg;

    localparam int WINDOW_LEN_DEF    = 3;
    localparam int MODEL_ENTRIES_DEF = 16;

    localparam logic [1:0]  MODE_CLASSIFY   = 2'd0;
    localparam logic [1:0]  MODE_TRAIN_MOVE = 2'd1;
    localparam logic [1:0]  MODE_TRAIN_STAT = 2'd2;
    localparam logic [1:0]  MODE_HALT       = 2'd3;

    localparam logic [1:0]  REG_RUN_MODE    = 2'd0;
    localparam logic [1:0]  REG_NOISE_FLOOR = 2'd1;
    localparam logic [1:0]  REG_WARMUP      = 2'd2;
    localparam logic [1:0]  REG_LIMIT       = 2'd3;

    localparam logic [7:0]  NOISE_FLOOR_RST = 8'd10;
    localparam logic [3:0]  WARMUP_RST      = 4'd3;
    localparam logic [15:0] LIMIT_RST       = 16'd128;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATE,
        ST_MEAN,
        ST_DEV,
        ST_SQRT,
        ST_VOTE,
        ST_OUT
    } awc_state_t;

endpackage

@@ rtl/awc_isqrt.sv @@
// Iterative integer square root, one result bit per cycle
module awc_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [19:0] radicand,
    output logic        done,
    output logic [9:0]  root
);
    // restoring method on a 20-bit radicand, one result bit per cycle
    logic [19:0] rem_reg, rem_next;
    logic [19:0] root_reg, root_next;
    logic [19:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [19:0] trial;

    always_comb begin
        trial     = root_reg + bit_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = radicand;
            root_next = '0;
            bit_next  = 20'h40000;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end else begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == 20'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign done = done_reg;
    assign root = root_reg[9:0];

    `include "activity_window_classifier_assert.svh"
    `AWC_ASSERT(a_no_start_busy, !(start && busy_reg))
    `AWC_ASSERT(a_done_idle, done_reg |-> !busy_reg)
    `AWC_ASSERT(a_done_once, done_reg |=> !done_reg)
endmodule

@@ rtl/activity_window_classifier.sv @@
// Top level: accelerometer window features and nearest-model vote classifier
//
//  channel | dir | tdata (low bit up)                        | handshake / extra
//  s_axis  | in  | accel_x[7:0] accel_y[15:8] accel_z[23:16] | s_tvalid/s_tready
//  m_axis  | out | class mean spread mov stat total trained   | tlast = run_finished
//  cfg     | in  | cfg_wr_en, cfg_index, cfg_wdata           | write only
//
// A sample that does not close a window is taken and leaves the block idle. A closing
// sample runs gating, mean and deviation sums, two square roots on the shared root
// unit and, in recognition, a walk over the MODEL_ENTRIES entry pairs, then loads
// the result. Reset is synchronous, active low; the model tables sit in flip-flops
// cleared by reset. Input is stalled while a window is in work; a finished window
// waits in the load step only while the previous result still awaits transfer.
module activity_window_classifier
    import awc_pkg::*;
#(
    parameter int WINDOW_LEN    = WINDOW_LEN_DEF,
    parameter int MODEL_ENTRIES = MODEL_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // accel_x, accel_y, accel_z
    output logic        m_tvalid,
    input  logic        m_tready,
    // activity_class[0] mean_magnitude[9:1] spread_magnitude[18:10]
    // moving_total[34:19] stationary_total[50:35] classified_total[66:51]
    // trained_entries[71:67]
    output logic [71:0] m_tdata,
    output logic        m_tlast,   // run_finished
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    localparam int WB = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int EB = (MODEL_ENTRIES > 1) ? $clog2(MODEL_ENTRIES) : 1;
    localparam int TB = $clog2(MODEL_ENTRIES + 1);
    localparam int SB = 10; // sum of up to four 8-bit samples
    localparam int CB = $clog2(2 * MODEL_ENTRIES + 1);

    // configuration
    logic [1:0]  mode_reg;
    logic [7:0]  floor_reg;
    logic [3:0]  warm_reg;
    logic [15:0] limit_reg;

    // run state
    logic [7:0]    win_reg [WINDOW_LEN][3];
    logic [WB:0]   fill_reg;
    logic [TB-1:0] tidx_reg;
    logic [3:0]    seen_reg;
    logic [15:0]   cmov_reg, cstat_reg, ctot_reg;
    logic [17:0]   smodel_reg [MODEL_ENTRIES];
    logic [17:0]   mmodel_reg [MODEL_ENTRIES];

    awc_state_t    st_reg, st_next;
    logic [WB-1:0] i_reg;
    logic [1:0]    a_reg;
    logic [EB-1:0] e_reg;
    logic [SB-1:0] acc_reg;
    logic [7:0]    mean_reg [3];
    logic [19:0]   msq_reg, dsq_reg;
    logic          sq_sel_reg;
    logic [8:0]    mmag_reg, smag_reg;
    logic [CB-1:0] mv_reg, sv_reg;
    logic [71:0]   out_reg;
    logic          last_reg;
    logic          ov_reg;

    logic done_rec, finished, accept, closes, do_use, step_last, win_last, out_go;
    logic [7:0]    samp, dabs;
    logic [SB-1:0] step_val, tot;
    logic [7:0]    q;
    logic [15:0]   sq;
    logic        sqrt_start, sqrt_done;
    logic [9:0]  sqrt_root;
    logic [19:0] sqrt_in;

    assign done_rec = (ctot_reg != 16'd0) && (ctot_reg >= limit_reg);
    assign finished = (mode_reg == MODE_CLASSIFY) ? done_rec :
                      (mode_reg == MODE_HALT) ? 1'b1 : (tidx_reg >= TB'(MODEL_ENTRIES));
    assign s_tready = (st_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign do_use   = !finished && !((mode_reg != MODE_CLASSIFY) && (seen_reg < warm_reg));
    assign closes   = (fill_reg == (WB+1)'(WINDOW_LEN - 1));
    assign win_last = (i_reg == WB'(WINDOW_LEN - 1));
    assign step_last = win_last && (a_reg == 2'd2);
    // result load waits until the output register is free or empties this cycle
    assign out_go   = (st_reg == ST_OUT) && (!ov_reg || m_tready);

    assign samp = win_reg[i_reg][a_reg];
    assign dabs = (samp > mean_reg[a_reg]) ? samp - mean_reg[a_reg] : mean_reg[a_reg] - samp;
    assign step_val = SB'((st_reg == ST_MEAN) ? samp : dabs);
    assign tot  = acc_reg + step_val;
    assign q    = tot[9:2];
    assign sq   = q * q;     // shared squarer
    assign sqrt_start = (st_reg == ST_SQRT) && (a_reg == 2'd0);
    assign sqrt_in    = sq_sel_reg ? dsq_reg : msq_reg;

    awc_isqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start),
        .radicand(sqrt_in), .done(sqrt_done), .root(sqrt_root)
    );

    // vote compare for the current entry pair
    logic [8:0] dsm, dss, dmm, dms;
    always_comb begin
        logic [8:0] sm, ss, mm, ms;
        sm = smodel_reg[e_reg][17:9];
        ss = smodel_reg[e_reg][8:0];
        mm = mmodel_reg[e_reg][17:9];
        ms = mmodel_reg[e_reg][8:0];
        dsm = (sm > mmag_reg) ? sm - mmag_reg : mmag_reg - sm;
        dss = (ss > smag_reg) ? ss - smag_reg : smag_reg - ss;
        dmm = (mm > mmag_reg) ? mm - mmag_reg : mmag_reg - mm;
        dms = (ms > smag_reg) ? ms - smag_reg : smag_reg - ms;
    end

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (accept && do_use && closes) st_next = ST_GATE;
            ST_GATE: if (win_last) st_next = ST_MEAN;
            ST_MEAN: if (step_last) st_next = ST_DEV;
            ST_DEV:  if (step_last) st_next = ST_SQRT;
            ST_SQRT: if (sqrt_done && sq_sel_reg)
                         st_next = (mode_reg == MODE_CLASSIFY) ? ST_VOTE : ST_OUT;
            ST_VOTE: if (e_reg == EB'(MODEL_ENTRIES - 1)) st_next = ST_OUT;
            ST_OUT:  if (out_go) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            mode_reg  <= MODE_CLASSIFY;
            floor_reg <= NOISE_FLOOR_RST;
            warm_reg  <= WARMUP_RST;
            limit_reg <= LIMIT_RST;
            fill_reg  <= '0;
            tidx_reg  <= '0;
            seen_reg  <= '0;
            cmov_reg  <= '0;
            cstat_reg <= '0;
            ctot_reg  <= '0;
            ov_reg    <= 1'b0;
            i_reg     <= '0;
            a_reg     <= '0;
            e_reg     <= '0;
            for (int k = 0; k < MODEL_ENTRIES; k++) begin
                smodel_reg[k] <= '0;
                mmodel_reg[k] <= '0;
            end
        end else begin
            st_reg <= st_next;
            if (!out_go && m_tvalid && m_tready) ov_reg <= 1'b0;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_RUN_MODE: begin
                        mode_reg  <= cfg_wdata[1:0];
                        fill_reg  <= '0;
                        seen_reg  <= '0;
                        tidx_reg  <= '0;
                        cmov_reg  <= '0;
                        cstat_reg <= '0;
                        ctot_reg  <= '0;
                    end
                    REG_NOISE_FLOOR: floor_reg <= cfg_wdata[7:0];
                    REG_WARMUP:      warm_reg  <= cfg_wdata[3:0];
                    REG_LIMIT:       limit_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            case (st_reg)
                ST_IDLE: begin
                    i_reg <= '0;
                    a_reg <= '0;
                    e_reg <= '0;
                    acc_reg <= '0;
                    msq_reg <= '0;
                    dsq_reg <= '0;
                    sq_sel_reg <= 1'b0;
                    mv_reg <= '0;
                    sv_reg <= '0;
                    if (accept && !finished) begin
                        if (!do_use) begin
                            seen_reg <= seen_reg + 4'd1;
                        end else begin
                            win_reg[fill_reg[WB-1:0]][0] <= s_tdata[7:0];
                            win_reg[fill_reg[WB-1:0]][1] <= s_tdata[15:8];
                            win_reg[fill_reg[WB-1:0]][2] <= s_tdata[23:16];
                            fill_reg <= closes ? '0 : fill_reg + 1'b1;
                        end
                    end
                end
                ST_GATE: begin
                    if (win_reg[i_reg][0] < floor_reg || win_reg[i_reg][1] < floor_reg ||
                        win_reg[i_reg][2] < floor_reg) begin
                        for (int k = 0; k < 3; k++)
                            if (win_reg[i_reg][k] <= floor_reg) win_reg[i_reg][k] <= '0;
                    end
                    i_reg <= win_last ? '0 : i_reg + 1'b1;
                end
                ST_MEAN, ST_DEV: begin
                    if (win_last) begin
                        i_reg <= '0;
                        a_reg <= (a_reg == 2'd2) ? 2'd0 : a_reg + 2'd1;
                        acc_reg <= '0;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                        acc_reg <= tot;
                    end
                end
                default: ;
            endcase
            // finish a per-axis sum: latch mean or accumulate squares
            if ((st_reg == ST_MEAN || st_reg == ST_DEV) && win_last) begin
                if (st_reg == ST_MEAN) begin
                    mean_reg[a_reg] <= q;
                    msq_reg <= msq_reg + 20'(sq);
                end else begin
                    dsq_reg <= dsq_reg + 20'(sq);
                end
            end
            if (st_reg == ST_SQRT) begin
                a_reg <= sqrt_done ? 2'd0 : 2'd1;
                if (sqrt_done) begin
                    sq_sel_reg <= 1'b1;
                    if (sq_sel_reg) smag_reg <= sqrt_root[8:0];
                    else mmag_reg <= sqrt_root[8:0];
                end
            end
            if (st_reg == ST_VOTE) begin
                e_reg <= e_reg + 1'b1;
                mv_reg <= mv_reg + CB'(dmm < dsm) + CB'(dms < dss);
                sv_reg <= sv_reg + CB'(!(dmm < dsm)) + CB'(!(dms < dss));
            end
            if (out_go) begin
                logic c;
                logic [15:0] nm, ns, nt;
                logic [TB-1:0] ti;
                c  = 1'b0;
                nm = cmov_reg; ns = cstat_reg; nt = ctot_reg;
                ti = '0;
                if (mode_reg == MODE_CLASSIFY) begin
                    c  = mv_reg > sv_reg;
                    nt = ctot_reg + 16'd1;
                    if (c) nm = cmov_reg + 16'd1; else ns = cstat_reg + 16'd1;
                    cmov_reg <= nm; cstat_reg <= ns; ctot_reg <= nt;
                end else begin
                    ti = tidx_reg + 1'b1;
                    tidx_reg <= ti;
                    if (mode_reg == MODE_TRAIN_MOVE)
                        mmodel_reg[tidx_reg[EB-1:0]] <= {mmag_reg, smag_reg};
                    else
                        smodel_reg[tidx_reg[EB-1:0]] <= {mmag_reg, smag_reg};
                end
                out_reg  <= {5'(ti), nt, ns, nm, smag_reg, mmag_reg, c};
                last_reg <= (mode_reg == MODE_CLASSIFY) ? (nt != 16'd0 && nt >= limit_reg)
                                : (ti >= TB'(MODEL_ENTRIES));
                ov_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = last_reg;

    `include "activity_window_classifier_assert.svh"
    `AWC_ASSERT(a_busy_no_ready, (st_reg != ST_IDLE) |-> !s_tready)
    `AWC_ASSERT(a_out_holds, (m_tvalid && !m_tready) |=> m_tvalid)
    `AWC_ASSERT(a_out_stable, (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
    `AWC_ASSERT(a_votes_sum, (st_reg == ST_OUT && mode_reg == MODE_CLASSIFY) |->
        (mv_reg + sv_reg == CB'(2 * MODEL_ENTRIES)))
endmodule

@@ test/activity_window_classifier_tb.sv @@
// Testbench for activity_window_classifier: predicts every window result and checks all transfers
module activity_window_classifier_tb;
    import awc_pkg::*;

    localparam int NWIN     = WINDOW_LEN_DEF;
    localparam int NENT     = MODEL_ENTRIES_DEF;
    localparam int N_ITEMS  = 1950;
    localparam int MAX_CYC  = 1000000;
    localparam int SETTLE   = 100;   // well above the window latency
    localparam int LONG_STALL = 400;

    // expected fields of one result transfer
    typedef struct {
        logic        cls;
        logic [8:0]  mmag;
        logic [8:0]  smag;
        logic [15:0] mov;
        logic [15:0] stat;
        logic [15:0] total;
        logic [4:0]  trained;
        logic        fin;
    } window_result_t;

    // predictor of the classifier plus queue of pending results
    class window_scoreboard;
        window_result_t pending[$];
        int             fails;
        logic [1:0]     mode;
        logic [7:0]     floor_lvl;
        logic [3:0]     warmup;
        logic [15:0]    limit;
        logic [7:0]     win[NWIN][3];
        int             fill;
        logic [17:0]    stat_tab[NENT];
        logic [17:0]    move_tab[NENT];
        int             tr_idx;
        int             warm_cnt;
        logic [15:0]    cnt_mov, cnt_stat, cnt_total;

        function new();
            mode = MODE_CLASSIFY;
            floor_lvl = NOISE_FLOOR_RST;
            warmup = WARMUP_RST;
            limit = LIMIT_RST;
            fails = 0;
            for (int i = 0; i < NENT; i++) begin
                stat_tab[i] = '0;
                move_tab[i] = '0;
            end
            for (int i = 0; i < NWIN; i++)
                for (int a = 0; a < 3; a++) win[i][a] = '0;
            restart();
        endfunction

        function void restart();
            fill = 0;
            warm_cnt = 0;
            tr_idx = 0;
            cnt_mov = '0;
            cnt_stat = '0;
            cnt_total = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_RUN_MODE: begin
                    mode = val[1:0];
                    restart();
                end
                REG_NOISE_FLOOR: floor_lvl = val[7:0];
                REG_WARMUP:      warmup = val[3:0];
                REG_LIMIT:       limit = val;
                default: ;
            endcase
        endfunction

        function bit recog_finished();
            return cnt_total != 0 && cnt_total >= limit;
        endfunction

        // floor square root, bit by bit from the top
        function logic [8:0] floor_root(int unsigned v);
            int unsigned r;
            r = 0;
            for (int b = 9; b >= 0; b--)
                if (((r | (1 << b)) * (r | (1 << b))) <= v) r = r | (1 << b);
            return r[8:0];
        endfunction

        function int unsigned abs_gap(int unsigned p, int unsigned q);
            return p > q ? p - q : q - p;
        endfunction

        // accepted sample: update state, queue a result if a window closes
        function void note_sample(logic [7:0] ax, logic [7:0] ay, logic [7:0] az);
            int unsigned s[NWIN][3];
            int unsigned mean[3], dev[3];
            int unsigned sum, msq, dsq, mv, sv;
            window_result_t r;
            if (mode == MODE_HALT) return;
            if (mode != MODE_CLASSIFY) begin
                if (tr_idx >= NENT) return;
                if (warm_cnt < warmup) begin
                    warm_cnt++;
                    return;
                end
            end else if (recog_finished()) begin
                return;
            end
            win[fill][0] = ax;
            win[fill][1] = ay;
            win[fill][2] = az;
            fill++;
            if (fill < NWIN) return;
            fill = 0;
            // gating: only when some axis is strictly under the floor
            for (int i = 0; i < NWIN; i++) begin
                bit low;
                low = 0;
                for (int a = 0; a < 3; a++) begin
                    s[i][a] = win[i][a];
                    if (win[i][a] < floor_lvl) low = 1;
                end
                if (low)
                    for (int a = 0; a < 3; a++)
                        if (s[i][a] <= floor_lvl) s[i][a] = 0;
            end
            msq = 0;
            dsq = 0;
            for (int a = 0; a < 3; a++) begin
                sum = 0;
                for (int i = 0; i < NWIN; i++) sum += s[i][a];
                mean[a] = sum >> 2;
                sum = 0;
                for (int i = 0; i < NWIN; i++) sum += abs_gap(s[i][a], mean[a]);
                dev[a] = sum >> 2;
                msq += mean[a] * mean[a];
                dsq += dev[a] * dev[a];
            end
            r.mmag = floor_root(msq);
            r.smag = floor_root(dsq);
            r.cls = 0;
            r.trained = '0;
            if (mode != MODE_CLASSIFY) begin
                if (mode == MODE_TRAIN_MOVE) move_tab[tr_idx] = {r.mmag, r.smag};
                else stat_tab[tr_idx] = {r.mmag, r.smag};
                tr_idx++;
                r.trained = tr_idx[4:0];
                r.fin = tr_idx >= NENT;
            end else begin
                mv = 0;
                sv = 0;
                for (int i = 0; i < NENT; i++) begin
                    if (abs_gap(move_tab[i][17:9], r.mmag) < abs_gap(stat_tab[i][17:9], r.mmag))
                        mv++;
                    else sv++;
                    if (abs_gap(move_tab[i][8:0], r.smag) < abs_gap(stat_tab[i][8:0], r.smag))
                        mv++;
                    else sv++;
                end
                r.cls = mv > sv;
                cnt_total++;
                if (r.cls) cnt_mov++;
                else cnt_stat++;
                r.fin = recog_finished();
            end
            r.mov = cnt_mov;
            r.stat = cnt_stat;
            r.total = cnt_total;
            pending.push_back(r);
        endfunction

        function void fail_field(string nm, longint unsigned e, longint unsigned a);
            $display("%0t: mismatch %s expected %0d actual %0d", $time, nm, e, a);
            fails++;
        endfunction

        function void check_result(logic [71:0] d, logic last);
            window_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result transfer %h", $time, d);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (d[0] !== e.cls)          fail_field("activity_class", e.cls, d[0]);
            if (d[9:1] !== e.mmag)       fail_field("mean_magnitude", e.mmag, d[9:1]);
            if (d[18:10] !== e.smag)     fail_field("spread_magnitude", e.smag, d[18:10]);
            if (d[34:19] !== e.mov)      fail_field("moving_total", e.mov, d[34:19]);
            if (d[50:35] !== e.stat)     fail_field("stationary_total", e.stat, d[50:35]);
            if (d[66:51] !== e.total)    fail_field("classified_total", e.total, d[66:51]);
            if (d[71:67] !== e.trained)  fail_field("trained_entries", e.trained, d[71:67]);
            if (last !== e.fin)          fail_field("run_finished", e.fin, last);
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // accel_x, accel_y, accel_z
    logic        m_tvalid;
    logic        m_tready = 0;
    // class, mean, spread, moving, stationary, total, trained
    logic [71:0] m_tdata;
    logic        m_tlast;        // run finished
    logic        cfg_wr_en = 0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    window_scoreboard sb;
    int  n_sent = 0;
    int  cycles = 0;
    bit  no_idle = 0;      // set for a quiet stretch with no gaps on either side
    bit  stall_req = 0;    // asks the receiver for one long hold-off
    int  stall_left = 0;

    activity_window_classifier dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast,
        .cfg_wr_en, .cfg_index, .cfg_wdata
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("FAIL activity_window_classifier");
            $finish;
        end
    end

    // receiver: checks each transfer, drives tready with random and long stalls
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        if (stall_req && stall_left == 0) begin
            stall_req <= 0;
            stall_left <= LONG_STALL;
            m_tready <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= (stall_left == 1);
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 6);
        end
    end

    task automatic send_sample(logic [7:0] ax, logic [7:0] ay, logic [7:0] az);
        while (!no_idle && $urandom_range(99) < 6) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {az, ay, ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(ax, ay, az);
        n_sent++;
    endtask

    // block idle: every result in, then the window latency once more
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    // axis values biased towards the floor edges and the range ends
    function automatic logic [7:0] pick_axis();
        int k;
        k = $urandom_range(15);
        if (k < 4) return sb.floor_lvl + 8'($urandom_range(2)) - 8'd1;
        if (k == 4) return 8'd0;
        if (k == 5) return 8'd255;
        if (k == 6) return 8'($urandom_range(20));
        return 8'($urandom);
    endfunction

    task automatic send_random(int n);
        for (int i = 0; i < n; i++) send_sample(pick_axis(), pick_axis(), pick_axis());
    endtask

    initial begin
        int phase, m, n;
        logic [15:0] lim;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: recognition against cleared tables, extremes and floor edges;
        // the receiver holds off meanwhile so that the block fills and stalls
        stall_req = 1;
        send_sample(0, 0, 0);       send_sample(255, 255, 255); send_sample(0, 255, 0);
        send_sample(255, 255, 255); send_sample(255, 255, 255); send_sample(255, 255, 255);
        send_sample(9, 10, 11);     send_sample(10, 10, 10);    send_sample(11, 200, 9);
        drain();
        // train moving with no warmup and a floor of zero, fills the table
        write_reg(REG_NOISE_FLOOR, 16'd0);
        write_reg(REG_WARMUP, 16'd0);
        write_reg(REG_RUN_MODE, 16'(MODE_TRAIN_MOVE));
        send_random(48);
        send_sample(1, 2, 3);       // table full: ignored
        drain();
        // halted mode ignores samples
        write_reg(REG_RUN_MODE, 16'(MODE_HALT));
        send_sample(100, 100, 100); send_sample(1, 1, 1); send_sample(7, 7, 7);
        drain();
        // limit of zero behaves like one
        write_reg(REG_NOISE_FLOOR, 16'd255);
        write_reg(REG_LIMIT, 16'd0);
        write_reg(REG_RUN_MODE, 16'(MODE_CLASSIFY));
        send_sample(254, 255, 3);   send_sample(255, 255, 255); send_sample(200, 0, 255);
        send_sample(5, 5, 5);
        drain();

        phase = 0;
        while (n_sent < N_ITEMS) begin
            phase++;
            no_idle = (phase == 6);
            m = $urandom_range(19);
            case ($urandom_range(7))
                0: write_reg(REG_NOISE_FLOOR, 16'd0);
                1: write_reg(REG_NOISE_FLOOR, 16'd255);
                default: write_reg(REG_NOISE_FLOOR, 16'($urandom_range(40)));
            endcase
            if (m == 0) begin
                write_reg(REG_RUN_MODE, 16'(MODE_HALT));
                send_random(3);
            end else if (m < 9) begin
                write_reg(REG_WARMUP, 16'($urandom_range(15)));
                write_reg(REG_RUN_MODE, 16'(m < 5 ? MODE_TRAIN_MOVE : MODE_TRAIN_STAT));
                if ($urandom_range(3) == 0) begin
                    // warmup count changed part way through the warmup
                    send_random($urandom_range(1, 3));
                    drain();
                    write_reg(REG_WARMUP, 16'($urandom_range(15)));
                end
                send_random(NWIN * NENT + 15 + $urandom_range(2));
            end else begin
                case ($urandom_range(9))
                    0: lim = 16'd65535;
                    1: lim = 16'd1;
                    default: lim = 16'($urandom_range(2, 30));
                endcase
                write_reg(REG_LIMIT, lim);
                write_reg(REG_RUN_MODE, 16'(MODE_CLASSIFY));
                n = (lim > 30 ? 30 : lim);
                if ($urandom_range(3) == 0 && n > 2) begin
                    // lower the limit to at most the count reached: run ends at once
                    send_random(NWIN * (n / 2));
                    drain();
                    write_reg(REG_LIMIT, 16'($urandom_range(1, n / 2)));
                    send_random(3);
                end else begin
                    send_random(NWIN * n + $urandom_range(2));
                end
            end
            drain();    // sender pauses until all results are in
        end
        no_idle = 0;
        drain();
        if (sb.fails == 0 && sb.pending.size() == 0) begin
            $display("PASS activity_window_classifier");
        end else begin
            $display("FAIL activity_window_classifier");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/awc_pkg.sv
rtl/awc_isqrt.sv
rtl/activity_window_classifier.sv
test/activity_window_classifier_tb.sv
